### rtl/assert_macros.svh
// Assertion helper macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock edge, also active during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent check on a clock edge, off while the active-low reset is low.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### rtl/som_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SOM package
// Shared widths, register indexes, divider status and the exp table step.
// ----------------------------------------------------------------------------
package som_pkg;

  localparam int DEF_MAX_SIDE       = 16;
  localparam int DEF_MAX_COMPONENTS = 16;
  localparam int DEF_GAUSS_DEPTH    = 256;

  localparam int WORD_W     = 16;
  localparam int DIST_W     = 36;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 5;

  // exp(-1/16) in Q0.32
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748381;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GRID_TOPOLOGY     = 3'd0,
    CFG_NEIGHBORHOOD_KIND = 3'd1,
    CFG_MAP_WIDTH         = 3'd2,
    CFG_MAP_HEIGHT        = 3'd3,
    CFG_VECTOR_LENGTH     = 3'd4
  } cfg_reg_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_status_t;

  // One step of the exp(-k/16) recurrence, Q32 fixed point
  function automatic logic [63:0] exp_step(input logic [63:0] e);
    logic [63:0] prod;
    prod = e * EXP_STEP_Q32 + 64'h8000_0000;
    return prod >> 32;
  endfunction

endpackage
`default_nettype wire

### rtl/som_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SOM generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module som_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/som_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SOM pattern cell
// One pattern component; loads from the input or takes its neighbor's word.
// ----------------------------------------------------------------------------
module som_cell
  import som_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic [WORD_W-1:0] load_val_i,
  input  wire logic              shift_i,
  input  wire logic [WORD_W-1:0] shift_val_i,
  output logic      [WORD_W-1:0] val_o
);

  logic [WORD_W-1:0] val_q;

  // Load has priority; loads only happen while the ring is at rest
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= load_val_i;
    end else if (shift_i) begin
      val_q <= shift_val_i;
    end
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

### rtl/som_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SOM table index divider
// Restoring division producing Q_W quotient bits, one bit per cycle,
// plus an overflow flag when the quotient does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module som_div
  import som_pkg::*;
#(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32,
  parameter int Q_W   = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [Q_W-1:0]   quot_o,
  output div_status_t           status_o
);

  localparam int XW  = NUM_W + DEN_W + Q_W;
  localparam int CTW = $clog2(Q_W + 1);

  logic [XW-1:0]  rem_q;
  logic [XW-1:0]  dsh_q;
  logic [CTW-1:0] cnt_q;
  logic [Q_W-1:0] quot_q;
  logic           busy_q;
  logic           done_q;
  logic           ovf_q;
  logic           ge;

  assign ge = (rem_q >= dsh_q);

  // First step tests for overflow, then one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= XW'(num_i);
        dsh_q  <= XW'(den_i) << Q_W;
        cnt_q  <= CTW'(Q_W);
        quot_q <= '0;
        ovf_q  <= 1'b0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q == CTW'(Q_W)) begin
          ovf_q <= ge;
        end else begin
          if (ge) begin
            rem_q <= rem_q - dsh_q;
          end
          quot_q <= {quot_q[Q_W-2:0], ge};
        end
        dsh_q <= dsh_q >> 1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CTW'(1);
        end
      end
    end
  end

  assign quot_o   = quot_q;
  assign status_o = '{busy: busy_q, done: done_q, ovf: ovf_q};

endmodule
`default_nettype wire

### rtl/som_winner_search_and_adapt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SOM winner search and adapt
// Kohonen map training step: codebook load, best matching unit search and
// neighborhood update, with the pattern held in a rotating row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser 0 writes one codebook word, tuser 1 stores one
//   pattern component; tlast on a pattern component starts search and adapt.
//   Codebook loads and other pattern components leave the input ready.
//   The search reads one codebook word per cycle through the single RAM read
//   port while the pattern ring rotates in step. In the adapt pass every unit
//   goes through S_GRID and S_SEL; a unit in the neighborhood then has its
//   words read, moved and written back, in Gaussian mode after the divider
//   (S_DIV, skipped for a zero radius) and the table lookup (S_WEIGHT,
//   S_ROUND). Units out of the neighborhood skip the word pass.
//   Master stream carries one result per pattern (winner and its distance).
//   tready on the slave side is low from a last component until the result
//   sits in the output register; the output register holds while the
//   receiver stalls, and the next work may not finish until it is taken.
//   Reset clears control state and configuration; the codebook and pattern
//   hold no reset value and need loading before use.
// ----------------------------------------------------------------------------
module som_winner_search_and_adapt
  import som_pkg::*;
#(
  parameter int MAX_SIDE          = DEF_MAX_SIDE,
  parameter int MAX_COMPONENTS    = DEF_MAX_COMPONENTS,
  parameter int GAUSS_TABLE_DEPTH = DEF_GAUSS_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // tdata: unit_x[3:0], unit_y[7:4], component_index[11:8],
  //        component_value[27:12], learning_rate[43:28],
  //        neighborhood_radius[59:44], zero fill
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tuser,  // req_type
  input  wire logic                  s_axis_tlast,  // last_component
  // tdata: winner_x[3:0], winner_y[7:4], winner_distance_sq[43:8], zero fill
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  wr_en_i,
  input  wire logic [CFG_ADDR_W-1:0] wr_addr_i,
  input  wire logic [CFG_DATA_W-1:0] wr_data_i
);

  localparam int SW    = $clog2(MAX_SIDE);
  localparam int SW1   = $clog2(MAX_SIDE + 1);
  localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CN1   = $clog2(MAX_COMPONENTS + 1);
  localparam int AW    = 2 * SW + CW;
  localparam int ACC_W = 32 + $clog2(MAX_COMPONENTS);
  localparam int MW    = (ACC_W > DIST_W) ? ACC_W : DIST_W;
  localparam int DW    = 2 * SW + 7;
  localparam int NW    = DW + 17;
  localparam int QW    = $clog2(GAUSS_TABLE_DEPTH);
  localparam int GBW   = (1 << QW) * WORD_W;
  localparam int CMPW  = DW + 14 + 32;

  // Gaussian weight table, exp(-k/16) in Q0.16, zero past the depth
  function automatic logic [GBW-1:0] build_gauss();
    logic [GBW-1:0] bits;
    logic [63:0]    e;
    logic [63:0]    t;
    bits = '0;
    e    = 64'h1_0000_0000;
    for (int k = 0; k < GAUSS_TABLE_DEPTH; k++) begin
      if (k > 0) begin
        e = exp_step(e);
      end
      t = (e + 64'd32768) >> 16;
      bits[k*WORD_W +: WORD_W] = (t > 64'd65535) ? 16'hFFFF : t[15:0];
    end
    return bits;
  endfunction

  localparam logic [GBW-1:0] GAUSS_BITS = build_gauss();

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DRAIN, S_GRID, S_SEL, S_DIV, S_WEIGHT, S_ROUND, S_DONE
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                  topo_q;
  logic                  nkind_q;
  logic [CFG_DATA_W-1:0] mw_q;
  logic [CFG_DATA_W-1:0] mh_q;
  logic [CFG_DATA_W-1:0] vl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topo_q  <= 1'b0;
      nkind_q <= 1'b0;
      mw_q    <= CFG_DATA_W'(16);
      mh_q    <= CFG_DATA_W'(16);
      vl_q    <= CFG_DATA_W'(16);
    end else if (wr_en_i) begin
      unique case (cfg_reg_e'(wr_addr_i))
        CFG_GRID_TOPOLOGY:     topo_q  <= wr_data_i[0];
        CFG_NEIGHBORHOOD_KIND: nkind_q <= wr_data_i[0];
        CFG_MAP_WIDTH:         mw_q    <= wr_data_i;
        CFG_MAP_HEIGHT:        mh_q    <= wr_data_i;
        CFG_VECTOR_LENGTH:     vl_q    <= wr_data_i;
        default: ;
      endcase
    end
  end

  // Clamped dimensions
  logic [SW1-1:0] w_eff;
  logic [SW1-1:0] h_eff;
  logic [CN1-1:0] n_eff;

  always_comb begin
    if (mw_q == '0) w_eff = SW1'(1);
    else if (32'(mw_q) > MAX_SIDE) w_eff = SW1'(MAX_SIDE);
    else w_eff = SW1'(mw_q);
    if (mh_q == '0) h_eff = SW1'(1);
    else if (32'(mh_q) > MAX_SIDE) h_eff = SW1'(MAX_SIDE);
    else h_eff = SW1'(mh_q);
    if (vl_q == '0) n_eff = CN1'(1);
    else if (32'(vl_q) > MAX_COMPONENTS) n_eff = CN1'(MAX_COMPONENTS);
    else n_eff = CN1'(vl_q);
  end

  // --------------------------------------------------------------------------
  // Input fields
  // --------------------------------------------------------------------------
  logic [3:0]        in_ux;
  logic [3:0]        in_uy;
  logic [3:0]        in_ci;
  logic [WORD_W-1:0] in_val;
  logic [15:0]       in_alpha;
  logic [15:0]       in_rad;
  logic              in_xfer;

  assign in_ux    = s_axis_tdata[3:0];
  assign in_uy    = s_axis_tdata[7:4];
  assign in_ci    = s_axis_tdata[11:8];
  assign in_val   = s_axis_tdata[27:12];
  assign in_alpha = s_axis_tdata[43:28];
  assign in_rad   = s_axis_tdata[59:44];

  state_e state_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  logic load_we;
  logic pat_ld;
  logic start_search;

  assign load_we = in_xfer && !s_axis_tuser && (32'(in_ux) < MAX_SIDE)
                   && (32'(in_uy) < MAX_SIDE) && (32'(in_ci) < MAX_COMPONENTS);
  assign pat_ld       = in_xfer && s_axis_tuser && (32'(in_ci) < MAX_COMPONENTS);
  assign start_search = in_xfer && s_axis_tuser && s_axis_tlast;

  // --------------------------------------------------------------------------
  // Pattern ring: the active cells rotate so cell 0 presents component z
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] ring_val [MAX_COMPONENTS];
  logic [WORD_W-1:0] ring_nb  [MAX_COMPONENTS];
  logic              issue;

  assign issue = (state_q == S_RD);

  for (genvar i = 0; i < MAX_COMPONENTS; i++) begin : g_ring
    if (i == MAX_COMPONENTS - 1) begin : g_wrap
      assign ring_nb[i] = ring_val[0];
    end else begin : g_mid
      assign ring_nb[i] = (CN1'(i + 1) == n_eff) ? ring_val[0] : ring_val[i+1];
    end
    som_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (pat_ld && (CW'(in_ci) == CW'(i))),
      .load_val_i (in_val),
      .shift_i    (issue && (CN1'(i) < n_eff)),
      .shift_val_i(ring_nb[i]),
      .val_o      (ring_val[i])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  logic              adapt_q;
  logic [SW-1:0]     x_q;
  logic [SW-1:0]     y_q;
  logic [CW-1:0]     z_q;
  logic [SW-1:0]     bx_q;
  logic [SW-1:0]     by_q;
  logic [ACC_W-1:0]  best_q;
  logic              have_q;
  logic [ACC_W-1:0]  acc_q;
  logic [15:0]       alpha_q;
  logic [15:0]       rad_q;
  logic [31:0]       r2_q;
  logic [DW-1:0]     grid_d_q;
  logic [QW-1:0]     gidx_q;
  logic [31:0]       wprod_q;
  logic [15:0]       a_q;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Pipeline registers
  logic              v1_q;
  logic              v2_q;
  logic [CW-1:0]     z1_q;
  logic [CW-1:0]     z2_q;
  logic [WORD_W-1:0] p1_q;
  logic [31:0]       prod_q;
  logic [WORD_W-1:0] w2_q;
  logic              neg2_q;

  logic drained;
  logic unit_last;
  logic y_end;
  logic z_end;
  logic [SW-1:0] x_nxt;
  logic [SW-1:0] y_nxt;

  assign drained   = !v1_q && !v2_q;
  assign y_end     = (SW1'(y_q) == h_eff - SW1'(1));
  assign unit_last = (SW1'(x_q) == w_eff - SW1'(1)) && y_end;
  assign z_end     = (CN1'(z_q) == n_eff - CN1'(1));
  assign x_nxt     = y_end ? x_q + SW'(1) : x_q;
  assign y_nxt     = y_end ? '0 : y_q + SW'(1);

  // --------------------------------------------------------------------------
  // Grid distance, 4 d^2, from winner to the current unit
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] dx_s;
  logic signed [DW-1:0] dy_s;
  logic signed [DW-1:0] h_s;
  logic signed [DW-1:0] hsq;
  logic signed [DW-1:0] dysq;
  logic        [DW-1:0] grid_d;

  always_comb begin
    dx_s = DW'($signed({1'b0, bx_q})) - DW'($signed({1'b0, x_q}));
    dy_s = DW'($signed({1'b0, by_q})) - DW'($signed({1'b0, y_q}));
    h_s  = dx_s <<< 1;
    if (topo_q && dy_s[0]) begin
      h_s = by_q[0] ? h_s + DW'(1) : h_s - DW'(1);
    end
    hsq  = h_s * h_s;
    dysq = dy_s * dy_s;
    grid_d = topo_q ? DW'(hsq + dysq + (dysq <<< 1)) : DW'(hsq + (dysq <<< 2));
  end

  // --------------------------------------------------------------------------
  // Table index divider
  // --------------------------------------------------------------------------
  logic        div_start;
  logic [QW-1:0] div_q;
  div_status_t div_st;

  assign div_start = (state_q == S_SEL) && nkind_q && (r2_q != '0);

  som_div #(
    .NUM_W(NW),
    .DEN_W(32),
    .Q_W  (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NW'(grid_d_q) << 17),
    .den_i   (r2_q),
    .quot_o  (div_q),
    .status_o(div_st)
  );

  logic bubble_in;
  assign bubble_in = (CMPW'(grid_d_q) << 14) <= CMPW'(r2_q);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [MW-1:0] best_ext;
  logic [DIST_W-1:0] dist_sat;

  assign best_ext = MW'(best_q);
  assign dist_sat = (best_ext > MW'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                    : best_ext[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      adapt_q     <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A taken result empties the output unless a new one replaces it
      if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_search) begin
            alpha_q <= in_alpha;
            rad_q   <= in_rad;
            adapt_q <= 1'b0;
            have_q  <= 1'b0;
            x_q     <= '0;
            y_q     <= '0;
            z_q     <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (z_end) begin
            z_q     <= '0;
            state_q <= S_DRAIN;
          end else begin
            z_q <= z_q + CW'(1);
          end
        end
        S_DRAIN: begin
          if (drained) begin
            if (!adapt_q) begin
              if (!have_q || acc_q < best_q) begin
                have_q <= 1'b1;
                best_q <= acc_q;
                bx_q   <= x_q;
                by_q   <= y_q;
              end
              if (unit_last) begin
                adapt_q <= 1'b1;
                x_q     <= '0;
                y_q     <= '0;
                state_q <= S_GRID;
              end else begin
                x_q     <= x_nxt;
                y_q     <= y_nxt;
                state_q <= S_RD;
              end
            end else if (unit_last) begin
              state_q <= S_DONE;
            end else begin
              x_q     <= x_nxt;
              y_q     <= y_nxt;
              state_q <= S_GRID;
            end
          end
        end
        S_GRID: begin
          grid_d_q <= grid_d;
          state_q  <= S_SEL;
        end
        S_SEL: begin
          if (!nkind_q) begin
            if (bubble_in) begin
              a_q     <= alpha_q;
              state_q <= S_RD;
            end else if (unit_last) begin
              state_q <= S_DONE;
            end else begin
              x_q     <= x_nxt;
              y_q     <= y_nxt;
              state_q <= S_GRID;
            end
          end else if (r2_q != '0) begin
            state_q <= S_DIV;
          end else if (grid_d_q == '0) begin
            gidx_q  <= '0;
            state_q <= S_WEIGHT;
          end else if (unit_last) begin
            state_q <= S_DONE;
          end else begin
            x_q     <= x_nxt;
            y_q     <= y_nxt;
            state_q <= S_GRID;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            if (!div_st.ovf && (32'(div_q) < GAUSS_TABLE_DEPTH)) begin
              gidx_q  <= div_q;
              state_q <= S_WEIGHT;
            end else if (unit_last) begin
              state_q <= S_DONE;
            end else begin
              x_q     <= x_nxt;
              y_q     <= y_nxt;
              state_q <= S_GRID;
            end
          end
        end
        S_WEIGHT: begin
          wprod_q <= alpha_q * GAUSS_BITS[{gidx_q, 4'b0000} +: WORD_W];
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          a_q     <= 16'((33'(wprod_q) + 33'd32768) >> 16);
          state_q <= S_RD;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {4'b0000, dist_sat, 4'(by_q), 4'(bx_q)};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Codebook memory
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] rd_data;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] adapt_word;

  assign ram_we    = load_we || (v2_q && adapt_q);
  assign ram_waddr = load_we ? {SW'(in_ux), SW'(in_uy), CW'(in_ci)} : {x_q, y_q, z2_q};
  assign ram_wdata = load_we ? in_val : adapt_word;

  som_ram #(
    .WIDTH(WORD_W),
    .DEPTH(1 << AW)
  ) u_codebook (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i({x_q, y_q, z_q}),
    .rdata_o(rd_data)
  );

  // --------------------------------------------------------------------------
  // Stream datapath: read, difference and product, accumulate or write back
  // --------------------------------------------------------------------------
  logic signed [16:0] diff_pw;
  logic               neg;
  logic [15:0]        mag;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] mul_p;
  logic               acc_clr;

  always_comb begin
    diff_pw = $signed({p1_q[15], p1_q}) - $signed({rd_data[15], rd_data});
    neg     = diff_pw[16];
    mag     = neg ? 16'(-diff_pw) : diff_pw[15:0];
    mul_a   = adapt_q ? $signed({1'b0, mag}) : diff_pw;
    mul_b   = adapt_q ? $signed({1'b0, a_q}) : diff_pw;
    mul_p   = mul_a * mul_b;
  end

  assign acc_clr = start_search || ((state_q == S_DRAIN) && drained);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= ring_val[0];
    z1_q   <= z_q;
    z2_q   <= z1_q;
    prod_q <= mul_p[31:0];
    w2_q   <= rd_data;
    neg2_q <= neg;
    r2_q   <= rad_q * rad_q;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (v2_q && !adapt_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Rounded step toward the pattern, saturated to the word range
  logic [32:0]        rnd;
  logic [16:0]        delta;
  logic signed [17:0] w_ext;
  logic signed [17:0] w_sum;

  always_comb begin
    rnd   = {1'b0, prod_q} + 33'd32768;
    delta = rnd[32:16];
    w_ext = 18'($signed(w2_q));
    w_sum = neg2_q ? w_ext - $signed({1'b0, delta}) : w_ext + $signed({1'b0, delta});
    if (w_sum > 18'sd32767) adapt_word = 16'h7FFF;
    else if (w_sum < -18'sd32768) adapt_word = 16'h8000;
    else adapt_word = w_sum[15:0];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

### rtl/som_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SOM port checker
// Checks handshake behavior of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module som_chk
  import som_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  s_axis_tuser,
  input wire logic                  s_axis_tlast,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // No result is offered while reset is held
  `ASSERT_CLK(a_rst_no_result, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

  // A stalled result holds
  `ASSERT_CLK_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

  // A last pattern component starts the search and blocks the input
  `ASSERT_CLK_RST(a_search_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast |=> !s_axis_tready, "input open during search")

  // Loads and plain pattern components leave the input ready in the next cycle
  `ASSERT_CLK_RST(a_quick_xfer, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !(s_axis_tuser && s_axis_tlast) |=> s_axis_tready, "load transfer blocked input")

  // A new result only appears at the end of a search
  `ASSERT_CLK_RST(a_result_src, clk_i, rst_ni, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without search")

endmodule

bind som_winner_search_and_adapt som_chk u_som_chk (.*);
`default_nettype wire
